// ===== src/ptme_pkg.sv =====
// Package with shared constants, types and helpers for the page table map/unmap engine.
package ptme_pkg;

  localparam int unsigned TablePagesDefault = 64;
  localparam int unsigned IdxW = 9;
  localparam int unsigned Entries = 512;
  localparam int unsigned PaW = 52;
  localparam int unsigned VaW = 48;
  localparam int unsigned FlagW = 12;
  localparam int unsigned EntryW = 64;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StOutOfTable = 2'd1,
    StNotMapped  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SInit,
    SIdle,
    SRead,
    SWait,
    SCheck,
    SClear,
    SLink,
    SLeaf,
    SDone
  } state_e;

  localparam logic [0:0] ReqMap = 1'b0;
  localparam logic [0:0] ReqUnmap = 1'b1;
  localparam logic [0:0] RegTableBase = 1'b0;

  // Leaf entry value for a map request.
  function automatic logic [PaW-1:0] leaf_value(input logic [PaW-1:0] pa,
                                                input logic [FlagW-1:0] fl);
    leaf_value = {pa[PaW-1:FlagW], fl | 12'h001};
  endfunction

endpackage

// ===== src/page_table_map_unmap_engine_top.sv =====
// Top level of the four-level page table map/unmap engine.
// Flow: each of three link levels is read and checked (SRead, SWait, SCheck), then
// the leaf is written (SLeaf) and the result registered (SDone). A walk can stop early
// at a missing link; every new table adds a clear of its 512 entries and a link write.
// Throughput: one item at a time; the next transfer is taken after the result leaves.
// Reset: asynchronous, active low. After reset all 512 entries of the root page are
// cleared before the first item is accepted; the allocator starts at page 1.
module page_table_map_unmap_engine_top
  import ptme_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = TablePagesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[0], virt_addr[48:1], phys_addr[100:49], page_flags[112:101]
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], leaf_entry[53:2], tables_allocated[55:54], tlb_invalidate[56]
  output logic [63:0]  m_axis_tdata
);

  localparam int unsigned PgW = $clog2(TABLE_PAGES);
  localparam int unsigned CntW = $clog2(TABLE_PAGES + 1);
  localparam int unsigned AddrW = PgW + IdxW;

  logic [EntryW-1:0] mem [TABLE_PAGES*Entries];
  logic [EntryW-1:0] rdata_q;
  logic              we;
  logic [AddrW-1:0]  maddr;
  logic [EntryW-1:0] wdata;

  // Single-port table memory with registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[maddr] <= wdata;
    end
    rdata_q <= mem[maddr];
  end

  logic [PaW-1:0] base_q;
  state_e state_q, state_d;
  logic [PgW-1:0] page_q, page_d, clrpg_q, clrpg_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [1:0] lvl_q, lvl_d, alloc_q, alloc_d;
  logic [CntW-1:0] nfree_q, nfree_d;
  logic unmap_q;
  logic [VaW-1:0] va_q;
  logic [PaW-1:0] pa_q;
  logic [FlagW-1:0] fl_q;
  logic [1:0] status_q, status_d;
  logic [PaW-1:0] leaf_q, leaf_d;
  logic inval_q, inval_d;
  logic [IdxW-1:0] idx;
  logic [PaW-1:0] off;
  logic [PaW-13:0] offpg;
  logic hit;
  logic accept;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegTableBase) ? {12'd0, base_q} : 64'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == RegTableBase) begin
      base_q <= pwdata[PaW-1:0];
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == SIdle) && !m_axis_tvalid;

  always_comb begin
    unique case (lvl_q)
      2'd0: idx = va_q[47:39];
      2'd1: idx = va_q[38:30];
      2'd2: idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  // Link decode: present and inside the pool.
  assign off = {rdata_q[PaW-1:12], 12'd0} - {base_q[PaW-1:12], 12'd0};
  assign offpg = off[PaW-1:12];
  assign hit = rdata_q[0] && (offpg < (PaW-12)'(TABLE_PAGES));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SInit:  if (cnt_q == IdxW'(Entries - 1)) state_d = SIdle;
      SIdle:  if (accept) state_d = SRead;
      SRead:  state_d = (lvl_q == 2'd3) ? SLeaf : SWait;
      SWait:  state_d = SCheck;
      SCheck: begin
        if (hit) state_d = SRead;
        else if (unmap_q || nfree_q >= CntW'(TABLE_PAGES)) state_d = SDone;
        else state_d = SClear;
      end
      SClear: if (cnt_q == IdxW'(Entries - 1)) state_d = SLink;
      SLink:  state_d = SRead;
      SLeaf:  state_d = SDone;
      SDone:  state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    page_d = page_q; clrpg_d = clrpg_q; cnt_d = cnt_q; lvl_d = lvl_q;
    alloc_d = alloc_q; nfree_d = nfree_q; status_d = status_q;
    leaf_d = leaf_q; inval_d = inval_q;
    we = 1'b0; maddr = {page_q, idx}; wdata = '0;
    unique case (state_q)
      SInit: begin
        we = 1'b1; maddr = {PgW'(0), cnt_q}; cnt_d = cnt_q + 1'b1;
      end
      SIdle: if (accept) begin
        page_d = '0; lvl_d = '0; alloc_d = '0; status_d = StOk;
        leaf_d = '0; inval_d = 1'b0;
      end
      SCheck: begin
        if (hit) begin
          page_d = offpg[PgW-1:0]; lvl_d = lvl_q + 1'b1;
        end else if (unmap_q) begin
          status_d = StNotMapped;
        end else if (nfree_q >= CntW'(TABLE_PAGES)) begin
          status_d = StOutOfTable;
        end else begin
          clrpg_d = nfree_q[PgW-1:0]; cnt_d = '0;
          nfree_d = nfree_q + 1'b1;
        end
      end
      SClear: begin
        we = 1'b1; maddr = {clrpg_q, cnt_q}; cnt_d = cnt_q + 1'b1;
      end
      SLink: begin
        we = 1'b1;
        wdata = {12'd0, base_q[PaW-1:12] + (PaW-12)'(clrpg_q), 12'h003};
        alloc_d = alloc_q + 1'b1; page_d = clrpg_q; lvl_d = lvl_q + 1'b1;
      end
      SLeaf: begin
        we = 1'b1;
        if (unmap_q == ReqUnmap) begin
          inval_d = 1'b1;
        end else begin
          wdata = {12'd0, leaf_value(pa_q, fl_q)};
          leaf_d = leaf_value(pa_q, fl_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit; cnt_q <= '0; nfree_q <= CntW'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; nfree_q <= nfree_d;
      if (state_q == SDone) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // Request and walk registers.
  always_ff @(posedge clk_i) begin
    page_q <= page_d; clrpg_q <= clrpg_d; lvl_q <= lvl_d; alloc_q <= alloc_d;
    status_q <= status_d; leaf_q <= leaf_d; inval_q <= inval_d;
    if (accept) begin
      unmap_q <= s_axis_tdata[0];
      va_q <= s_axis_tdata[48:1];
      pa_q <= s_axis_tdata[100:49];
      fl_q <= s_axis_tdata[112:101];
    end
    if (state_q == SDone) begin
      m_axis_tdata <= {7'd0, inval_q, alloc_q, leaf_q, status_q};
    end
  end

endmodule

// ===== src/ptme_checker.sv =====
// Port-level checker for the page table engine, bound to the top level.
module ptme_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad status");

  a_fail_no_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[53:2] == 52'd0
    && !m_axis_tdata[56]) else $error("failed request wrote leaf");

endmodule

bind page_table_map_unmap_engine_top ptme_sva u_ptme_sva (.*);

// ===== sim/ptme_checker.sv =====
// Checker for the page table engine: it tracks table state, predicts each response and compares.
`timescale 1ns / 1ps

module ptme_checker
  import ptme_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = TablePagesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         pready,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);

  localparam logic [2:0] TableBaseAddr = 3'(8 * RegTableBase);
  localparam logic [PaW-1:0] AddrMask = {{(PaW-12){1'b1}}, 12'h000};

  typedef struct packed {
    status_e        status;
    logic [PaW-1:0] leaf;
    logic [1:0]     tables_new;
    logic           tlb_inval;
  } walk_result_t;

  // Model of the table pool; entries never written read as zero.
  logic [EntryW-1:0] pool_entries [int];
  int unsigned       free_page;
  logic [PaW-1:0]    pool_base;
  walk_result_t      responses_due [$];
  int                mismatches;

  assign fail_count_o = mismatches;
  assign pending_o = responses_due.size();

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [EntryW-1:0] read_entry(input int unsigned slot);
    return pool_entries.exists(slot) ? pool_entries[slot] : '0;
  endfunction

  // Physical address of a pool page, wrapped to the address width.
  function automatic logic [PaW-1:0] page_addr(input int unsigned pg);
    logic [PaW-1:0] offs;
    offs = PaW'(pg) << 12;
    return (pool_base & AddrMask) + offs;
  endfunction

  // Walks the tables for one request and updates the model as the engine would.
  function automatic walk_result_t walk_tables(input logic [119:0] req);
    logic           unmap;
    logic [VaW-1:0] va;
    logic [PaW-1:0] pa;
    logic [FlagW-1:0] fl;
    logic [IdxW-1:0] idx [4];
    logic [PaW-1:0] offs;
    logic [EntryW-1:0] link;
    int unsigned    pg;
    int unsigned    slot;
    walk_result_t   res;
    unmap = req[0];
    va = req[48:1];
    pa = req[100:49];
    fl = req[112:101];
    res = '{status: StOk, leaf: '0, tables_new: '0, tlb_inval: 1'b0};
    idx[0] = va[47:39];
    idx[1] = va[38:30];
    idx[2] = va[29:21];
    idx[3] = va[20:12];
    pg = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      slot = pg * Entries + idx[lvl];
      link = read_entry(slot);
      offs = (link[PaW-1:0] & AddrMask) - (pool_base & AddrMask);
      // A present link that lands inside the pool is followed.
      if (link[0] && (offs >> 12) < TABLE_PAGES) begin
        pg = int'(offs >> 12);
        continue;
      end
      if (unmap) begin
        res.status = StNotMapped;
        break;
      end
      if (free_page >= TABLE_PAGES) begin
        res.status = StOutOfTable;
        break;
      end
      for (int e = 0; e < Entries; e++) pool_entries.delete(free_page * Entries + e);
      pool_entries[slot] = EntryW'(page_addr(free_page) | PaW'(3));
      pg = free_page;
      free_page++;
      res.tables_new++;
    end
    if (res.status == StOk) begin
      slot = pg * Entries + idx[3];
      if (unmap) begin
        pool_entries[slot] = '0;
        res.tlb_inval = 1'b1;
      end else begin
        res.leaf = {pa[PaW-1:12], fl | 12'h001};
        pool_entries[slot] = EntryW'(res.leaf);
      end
    end
    return res;
  endfunction

  // Track register writes, predict accepted requests and check responses.
  always @(posedge clk_i or negedge rst_ni) begin
    walk_result_t want;
    if (!rst_ni) begin
      pool_entries.delete();
      free_page = 1;
      pool_base = '0;
      responses_due.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == TableBaseAddr) begin
        pool_base = pwdata[PaW-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        responses_due.push_back(walk_tables(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (responses_due.size() == 0) begin
          report_mismatch("response transfer with nothing outstanding");
        end else begin
          want = responses_due.pop_front();
          if (m_axis_tdata[1:0] != want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_axis_tdata[1:0], want.status));
          if (m_axis_tdata[53:2] != want.leaf)
            report_mismatch($sformatf("leaf_entry %h, want %h", m_axis_tdata[53:2], want.leaf));
          if (m_axis_tdata[55:54] != want.tables_new)
            report_mismatch($sformatf("tables_allocated %0d, want %0d",
                                      m_axis_tdata[55:54], want.tables_new));
          if (m_axis_tdata[56] != want.tlb_inval)
            report_mismatch($sformatf("tlb_invalidate %0b, want %0b",
                                      m_axis_tdata[56], want.tlb_inval));
        end
      end
    end
  end

endmodule

// ===== sim/page_table_map_unmap_engine_top_tb.sv =====
// Testbench top for the page table engine: stimulus, register phases, stalls and verdict.
`timescale 1ns / 1ps

module page_table_map_unmap_engine_top_tb;
  import ptme_pkg::*;

  localparam int IdleLimit = 20000;
  localparam logic [2:0] TableBaseAddr = 3'(8 * RegTableBase);

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // req_type[0], virt_addr[48:1], phys_addr[100:49], page_flags[112:101]
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // status[1:0], leaf_entry[53:2], tables_allocated[55:54], tlb_invalidate[56]
  logic [63:0]  m_axis_tdata;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  bit           steady_send = 1'b0;
  logic [IdxW-1:0] hot_top [2];
  logic [IdxW-1:0] hot_mid [2];
  logic [IdxW-1:0] hot_low [3];

  always #6 clk_i = ~clk_i;

  page_table_map_unmap_engine_top dut (.*);

  ptme_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(20, 4);
    return $urandom_range(300, 50);
  endfunction

  // Response side stalls; some stretches never stall.
  always @(posedge clk_i) begin
    int stall;
    int quiet;
    if (quiet > 0) begin
      quiet--;
      m_axis_tready <= 1'b1;
    end else if (stall > 0) begin
      stall--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) < 2) begin
      quiet = $urandom_range(2000, 300);
      m_axis_tready <= 1'b1;
    end else begin
      stall = gap_len();
      m_axis_tready <= (stall == 0);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input logic kind, input logic [VaW-1:0] va,
                          input logic [PaW-1:0] pa, input logic [FlagW-1:0] fl);
    int gap;
    s_axis_tdata <= {7'b0, fl, pa, va, kind};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    gap = steady_send ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lets every response arrive, then rewrites the pool base.
  task automatic set_table_base(input logic [63:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= TableBaseAddr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [PaW-1:0] rand_pa();
    return PaW'({$urandom, $urandom});
  endfunction

  // Random request: mostly addresses under a few shared tables, some anywhere.
  task automatic send_random();
    logic [VaW-1:0] va;
    logic kind;
    va = VaW'({$urandom, $urandom});
    if ($urandom_range(99) < 95) begin
      va[47:39] = hot_top[$urandom_range(1)];
      va[38:30] = hot_mid[$urandom_range(1)];
      va[29:21] = hot_low[$urandom_range(2)];
    end
    kind = ($urandom_range(99) < 60) ? ReqMap : ReqUnmap;
    send_req(kind, va, rand_pa(), FlagW'($urandom));
  endtask

  initial begin
    logic [VaW-1:0] va_lo;
    logic [VaW-1:0] va_hi;
    logic [63:0] bases [4];
    va_lo = '0;
    va_hi = '1;
    hot_top = '{9'd0, 9'h1FF};
    hot_mid = '{9'h1FF, 9'($urandom)};
    hot_low = '{9'd0, 9'h1FF, 9'($urandom)};
    bases = '{64'd0, '1, {$urandom, $urandom}, 64'd0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_table_base(bases[0]);

    // Directed requests around two extreme addresses.
    send_req(ReqUnmap, va_lo, '0, '0);
    send_req(ReqMap, va_lo, '0, '0);
    send_req(ReqMap, va_hi, '1, '1);
    send_req(ReqMap, va_lo, rand_pa(), FlagW'($urandom));
    send_req(ReqUnmap, va_lo, '0, '0);
    send_req(ReqUnmap, va_lo, '0, '0);
    send_req(ReqUnmap, va_lo ^ (48'd1 << 21), '0, '0);
    send_req(ReqUnmap, va_lo ^ (48'd1 << 30), '0, '0);
    send_req(ReqMap, va_lo ^ (48'd1 << 21), '1, 12'h0);
    send_req(ReqMap, va_lo ^ (48'd1 << 30), '0, '1);
    send_req(ReqUnmap, va_hi ^ (48'd1 << 12), '1, '1);
    send_req(ReqUnmap, va_hi, '1, '1);
    send_req(ReqMap, va_hi, 52'hA_AAAA_AAAA_A555, 12'hAAA);
    send_req(ReqMap, va_hi, 52'h5_5555_5555_5AAA, 12'h555);

    // Random phases, each under its own entry of bases (the first and last are both zero).
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) set_table_base(bases[ph]);
      for (int n = 0; n < 90; n++) begin
        steady_send = (n >= 40 && n < 60);
        send_random();
      end
    end
    steady_send = 1'b0;

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ptme_pkg.sv
src/page_table_map_unmap_engine_top.sv
src/ptme_checker.sv
sim/ptme_checker.sv
sim/page_table_map_unmap_engine_top_tb.sv
